@@ design/length_prefix_deframer_macros.svh @@
// Assertion macros shared by the deframer modules.
`ifndef LENGTH_PREFIX_DEFRAMER_MACROS_SVH
`define LENGTH_PREFIX_DEFRAMER_MACROS_SVH
`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset.
`define LPD_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Expression must never be true outside reset.
`define LPD_NEVER(label, clk, rst, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define LPD_ASSERT(label, clk, rst, prop, msg)
`define LPD_NEVER(label, clk, rst, expr, msg)
`endif
`endif

@@ design/lpd_pkg.sv @@
// Types and constants of the length-prefix deframer.
`timescale 1ns / 1ps
`default_nettype none
package lpd_pkg;

  localparam logic [31:0] MAX_LENGTH_RESET = 32'd16777216;

  typedef enum logic [1:0] {
    KIND_PAYLOAD  = 2'd0,
    KIND_OVERSIZE = 2'd1,
    KIND_ABORT    = 2'd2
  } kind_t;

  // One result beat.
  typedef struct packed {
    kind_t      kind;
    logic [7:0] payload;
    logic       message_last;
    logic       run_last;
  } result_t;

  // Results caused by one input beat: the byte result first, then the abort.
  typedef struct packed {
    logic    first_valid;
    result_t first;
    logic    second_valid;
    result_t second;
  } result_pair_t;

endpackage
`default_nettype wire

@@ design/length_prefix_deframer.sv @@
// Top level of the length-prefix deframer with its register port.
// Usage:
//   Input channel (in_valid/in_stall) carries one stream byte or an empty
//   event per beat, with chunk_end and stream_end marks. Each message is a
//   4-byte big-endian length then that many payload bytes; zero lengths vanish.
//   Output channel (out_valid/out_stall) carries one result per beat: a
//   payload byte (message_last on the final one), an oversize error, or an
//   abort when the stream closes mid-message. run_last marks the last result
//   caused by one input beat; an input beat yields zero, one or two results.
//   A result is queued as its input beat is taken, behind any waiting results.
//   Throughput: one input beat per cycle while the output side keeps up; an
//   input beat is taken whenever the OUT_DEPTH-entry result queue has room
//   for two more results; waiting results stall input only without that room.
//   A stalled receiver holds the head result; once fewer than two entries are
//   free, in_stall rises until the receiver drains the queue.
//   Register max_length sits at byte address 0 of the APB port and resets to
//   16 MiB. Reset clears the frame state and empties the result queue.
`timescale 1ns / 1ps
`default_nettype none
module length_prefix_deframer #(
  parameter int OUT_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        has_byte,
  input  logic        chunk_end,
  input  logic        stream_end,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  result_kind,
  output logic [7:0]  payload_byte,
  output logic        message_last,
  output logic        run_last,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import lpd_pkg::*;

  logic         max_length_sel;
  logic [31:0]  max_length;
  logic         room;
  logic         accept;
  result_pair_t results;
  result_t      head;

  // Only word 0 is implemented.
  assign max_length_sel = (paddr[2] == 1'b0);
  assign pready         = 1'b1;
  assign prdata         = max_length_sel ? max_length : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_length <= MAX_LENGTH_RESET;
    end else if (psel && penable && pwrite && max_length_sel) begin
      max_length <= pwdata;
    end
  end

  assign in_stall = !room;
  assign accept   = in_valid && room;

  lpd_core u_core (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .data_byte  (data_byte),
    .has_byte   (has_byte),
    .chunk_end  (chunk_end),
    .stream_end (stream_end),
    .max_length (max_length),
    .results    (results)
  );

  lpd_out_fifo #(
    .DEPTH (OUT_DEPTH)
  ) u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_data (results),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .head      (head)
  );

  assign result_kind  = head.kind;
  assign payload_byte = head.payload;
  assign message_last = head.message_last;
  assign run_last     = head.run_last;

endmodule
`default_nettype wire

@@ design/lpd_core.sv @@
// Header collection, payload counting and chunk dropping for one beat per cycle while accept is high.
`timescale 1ns / 1ps
`default_nettype none
`include "length_prefix_deframer_macros.svh"
module lpd_core (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 accept,
  input  logic [7:0]           data_byte,
  input  logic                 has_byte,
  input  logic                 chunk_end,
  input  logic                 stream_end,
  input  logic [31:0]          max_length,
  output lpd_pkg::result_pair_t results
);
  import lpd_pkg::*;

  logic [23:0] header_shift, header_shift_next;
  logic [1:0]  header_count, header_count_next;
  logic [31:0] remaining, remaining_next;
  logic        dropping, dropping_next;

  logic        byte_take;
  logic        pay;
  logic        hdr_done;
  logic        oversize;
  logic        abort;
  logic [31:0] remaining_dec;
  logic [31:0] length;

  always_comb begin
    byte_take     = has_byte && !dropping;
    pay           = byte_take && (remaining != 32'd0);
    hdr_done      = byte_take && (remaining == 32'd0) && (header_count == 2'd3);
    length        = {header_shift, data_byte};
    oversize      = hdr_done && (length != 32'd0) && (length > max_length);
    remaining_dec = remaining - 32'd1;

    header_shift_next = header_shift;
    header_count_next = header_count;
    remaining_next    = remaining;
    dropping_next     = dropping;

    if (pay) begin
      remaining_next = remaining_dec;
    end else if (byte_take && header_count != 2'd3) begin
      header_shift_next = {header_shift[15:0], data_byte};
      header_count_next = header_count + 2'd1;
    end else if (hdr_done) begin
      header_shift_next = 24'd0;
      header_count_next = 2'd0;
      if (oversize) begin
        dropping_next = 1'b1;
      end else begin
        remaining_next = length;
      end
    end

    if (chunk_end) begin
      dropping_next = 1'b0;
    end

    abort = stream_end && ((header_count_next != 2'd0) || (remaining_next != 32'd0));
    if (stream_end) begin
      header_shift_next = 24'd0;
      header_count_next = 2'd0;
      remaining_next    = 32'd0;
      dropping_next     = 1'b0;
    end

    results.first_valid           = pay || oversize;
    results.first.kind            = pay ? KIND_PAYLOAD : KIND_OVERSIZE;
    results.first.payload         = pay ? data_byte : 8'd0;
    results.first.message_last    = pay && (remaining_dec == 32'd0);
    results.first.run_last        = !abort;
    results.second_valid          = abort;
    results.second.kind           = KIND_ABORT;
    results.second.payload        = 8'd0;
    results.second.message_last   = 1'b0;
    results.second.run_last       = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      header_shift <= 24'd0;
      header_count <= 2'd0;
      remaining    <= 32'd0;
      dropping     <= 1'b0;
    end else if (accept) begin
      header_shift <= header_shift_next;
      header_count <= header_count_next;
      remaining    <= remaining_next;
      dropping     <= dropping_next;
    end
  end

  `LPD_ASSERT(a_close_clears, clk, rst, accept && stream_end |=> header_count == 2'd0 && remaining == 32'd0 && !dropping, "stream close left frame state behind")
  `LPD_ASSERT(a_oversize_drops, clk, rst, accept && oversize && !chunk_end && !stream_end |=> dropping, "oversize header did not start dropping")
  `LPD_NEVER(a_header_xor_payload, clk, rst, header_count != 2'd0 && remaining != 32'd0, "header collection during payload")

endmodule
`default_nettype wire

@@ design/lpd_out_fifo.sv @@
// Result queue taking up to two beats per cycle and giving one per cycle while out_stall is low.
`timescale 1ns / 1ps
`default_nettype none
`include "length_prefix_deframer_macros.svh"
module lpd_out_fifo #(
  parameter int DEPTH = 4
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  lpd_pkg::result_pair_t push_data,
  output logic                 room,
  output logic                 out_valid,
  input  logic                 out_stall,
  output lpd_pkg::result_t     head
);
  import lpd_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  result_t         entries [DEPTH];
  logic [PW-1:0]   wr_ptr, wr_ptr_next, wr_ptr_one;
  logic [PW-1:0]   rd_ptr, rd_ptr_next;
  logic [CW-1:0]   count, count_next;
  logic [CW-1:0]   push_n;
  logic            pop;
  logic            wr_a, wr_b;
  result_t         data_a, data_b;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    ptr_inc = (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  always_comb begin
    pop        = out_valid && !out_stall;
    wr_ptr_one = ptr_inc(wr_ptr);
    // Compact the pair so the first present result lands at the write pointer.
    wr_a   = push && (push_data.first_valid || push_data.second_valid);
    wr_b   = push && push_data.first_valid && push_data.second_valid;
    data_a = push_data.first_valid ? push_data.first : push_data.second;
    data_b = push_data.second;
    push_n = CW'(wr_a) + CW'(wr_b);
    wr_ptr_next = wr_b ? ptr_inc(wr_ptr_one) : (wr_a ? wr_ptr_one : wr_ptr);
    rd_ptr_next = pop ? ptr_inc(rd_ptr) : rd_ptr;
    count_next  = count + push_n - CW'(pop);
  end

  assign out_valid = (count != '0);
  assign room      = (count <= CW'(DEPTH - 2));
  assign head      = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      rd_ptr <= rd_ptr_next;
      count  <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_a) begin
      entries[wr_ptr] <= data_a;
    end
    if (wr_b) begin
      entries[wr_ptr_one] <= data_b;
    end
  end

  `LPD_NEVER(a_no_overflow, clk, rst, count > CW'(DEPTH), "result queue overflow")
  `LPD_NEVER(a_push_needs_room, clk, rst, push && !room, "push while queue lacks room")
  `LPD_ASSERT(a_abort_ends_run, clk, rst, out_valid && head.kind == KIND_ABORT |-> head.run_last, "abort beat not marked last of run")

endmodule
`default_nettype wire

@@ tb/length_prefix_deframer_tb.sv @@
// Self-checking testbench of the length-prefix deframer: directed table, then random framing.
`timescale 1ns / 1ps
module length_prefix_deframer_tb;
  import lpd_pkg::*;

  localparam logic [2:0] MAX_LENGTH_ADDR = 3'd0;
  localparam logic [2:0] UNUSED_ADDR     = 3'd4;
  localparam int SETTLE_CYCLES   = 4;
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int BEATS_PER_PHASE = 85;
  localparam int PHASES          = 6;
  localparam int DIRECTED_COUNT  = 25;

  typedef struct packed {
    logic [7:0] data;
    logic       has_byte;
    logic       chunk_end;
    logic       stream_end;
  } beat_t;

  // typed = 1: the expected results are given in the row, else the predictor supplies them
  typedef struct packed {
    beat_t       beat;
    logic        typed;
    logic [1:0]  count;
    result_t     r0;
    result_t     r1;
  } row_t;

  localparam result_t NO_RESULT     = '{KIND_PAYLOAD, 8'h00, 1'b0, 1'b0};
  localparam result_t OVERSIZE_RES  = '{KIND_OVERSIZE, 8'h00, 1'b0, 1'b0};
  localparam result_t ABORT_RES     = '{KIND_ABORT, 8'h00, 1'b0, 1'b0};
  localparam result_t OVERSIZE_LAST = '{KIND_OVERSIZE, 8'h00, 1'b0, 1'b1};
  localparam result_t ABORT_LAST    = '{KIND_ABORT, 8'h00, 1'b0, 1'b1};

  localparam row_t DIRECTED_ROWS [0:DIRECTED_COUNT-1] = '{
    // length two, then both payload bytes
    '{'{8'h00, 1'b1, 1'b0, 1'b0}, 1'b1, 2'd0, NO_RESULT, NO_RESULT},
    '{'{8'h00, 1'b1, 1'b0, 1'b0}, 1'b1, 2'd0, NO_RESULT, NO_RESULT},
    '{'{8'h00, 1'b1, 1'b0, 1'b0}, 1'b1, 2'd0, NO_RESULT, NO_RESULT},
    '{'{8'h02, 1'b1, 1'b0, 1'b0}, 1'b1, 2'd0, NO_RESULT, NO_RESULT},
    '{'{8'hAA, 1'b1, 1'b0, 1'b0}, 1'b1, 2'd1, '{KIND_PAYLOAD, 8'hAA, 1'b0, 1'b1}, NO_RESULT},
    '{'{8'h55, 1'b1, 1'b0, 1'b0}, 1'b1, 2'd1, '{KIND_PAYLOAD, 8'h55, 1'b1, 1'b1}, NO_RESULT},
    // zero-length message vanishes
    '{'{8'h00, 1'b1, 1'b0, 1'b0}, 1'b1, 2'd0, NO_RESULT, NO_RESULT},
    '{'{8'h00, 1'b1, 1'b0, 1'b0}, 1'b1, 2'd0, NO_RESULT, NO_RESULT},
    '{'{8'h00, 1'b1, 1'b0, 1'b0}, 1'b1, 2'd0, NO_RESULT, NO_RESULT},
    '{'{8'h00, 1'b1, 1'b0, 1'b0}, 1'b1, 2'd0, NO_RESULT, NO_RESULT},
    // empty event ignores its data
    '{'{8'hFF, 1'b0, 1'b0, 1'b0}, 1'b1, 2'd0, NO_RESULT, NO_RESULT},
    // largest length is oversize; drop to the end of the chunk
    '{'{8'hFF, 1'b1, 1'b0, 1'b0}, 1'b1, 2'd0, NO_RESULT, NO_RESULT},
    '{'{8'hFF, 1'b1, 1'b0, 1'b0}, 1'b1, 2'd0, NO_RESULT, NO_RESULT},
    '{'{8'hFF, 1'b1, 1'b0, 1'b0}, 1'b1, 2'd0, NO_RESULT, NO_RESULT},
    '{'{8'hFF, 1'b1, 1'b0, 1'b0}, 1'b1, 2'd1, OVERSIZE_LAST, NO_RESULT},
    '{'{8'h12, 1'b1, 1'b0, 1'b0}, 1'b0, 2'd0, NO_RESULT, NO_RESULT},
    '{'{8'h34, 1'b1, 1'b1, 1'b0}, 1'b0, 2'd0, NO_RESULT, NO_RESULT},
    // length three, closed after two bytes: payload then abort from one beat
    '{'{8'h00, 1'b1, 1'b0, 1'b0}, 1'b0, 2'd0, NO_RESULT, NO_RESULT},
    '{'{8'h00, 1'b1, 1'b0, 1'b0}, 1'b0, 2'd0, NO_RESULT, NO_RESULT},
    '{'{8'h00, 1'b1, 1'b0, 1'b0}, 1'b0, 2'd0, NO_RESULT, NO_RESULT},
    '{'{8'h03, 1'b1, 1'b0, 1'b0}, 1'b0, 2'd0, NO_RESULT, NO_RESULT},
    '{'{8'h11, 1'b1, 1'b0, 1'b0}, 1'b0, 2'd0, NO_RESULT, NO_RESULT},
    '{'{8'h80, 1'b1, 1'b0, 1'b1}, 1'b1, 2'd2, '{KIND_PAYLOAD, 8'h80, 1'b0, 1'b0}, ABORT_LAST},
    // close part-way through a header on an empty event
    '{'{8'h01, 1'b1, 1'b0, 1'b0}, 1'b0, 2'd0, NO_RESULT, NO_RESULT},
    '{'{8'h00, 1'b0, 1'b1, 1'b1}, 1'b1, 2'd1, ABORT_LAST, NO_RESULT}
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  data_byte = 8'h00;
  logic        has_byte = 1'b0;
  logic        chunk_end = 1'b0;
  logic        stream_end = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  result_kind;
  logic [7:0]  payload_byte;
  logic        message_last;
  logic        run_last;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = 3'd0;
  logic [31:0] pwdata = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  // predictor copy of the frame state and the register
  logic [23:0] hdr_shift = '0;
  logic [1:0]  hdr_count = '0;
  logic [31:0] remaining = '0;
  logic        dropping = 1'b0;
  logic [31:0] max_len = MAX_LENGTH_RESET;

  result_t step_results [$];
  result_t due_results [$];
  result_t head_result;
  int      mismatches = 0;
  int      quiet_cycles = 0;
  int      sent_beats = 0;
  int      send_idle_pct = 25;
  int      recv_idle_pct = 73;

  length_prefix_deframer DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .data_byte(data_byte), .has_byte(has_byte), .chunk_end(chunk_end),
    .stream_end(stream_end),
    .out_valid(out_valid), .out_stall(out_stall),
    .result_kind(result_kind), .payload_byte(payload_byte),
    .message_last(message_last), .run_last(run_last),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk = ~clk;

  // Advance the frame state by one beat and collect the results it causes.
  function automatic void deframe_beat(input beat_t b);
    result_t     r;
    logic [31:0] len;
    step_results.delete();
    if (b.has_byte && !dropping) begin
      if (remaining != 32'd0) begin
        remaining = remaining - 32'd1;
        r = '{KIND_PAYLOAD, b.data, remaining == 32'd0, 1'b0};
        step_results = {step_results, r};
      end else if (hdr_count != 2'd3) begin
        hdr_shift = {hdr_shift[15:0], b.data};
        hdr_count = hdr_count + 2'd1;
      end else begin
        len = {hdr_shift, b.data};
        hdr_shift = '0;
        hdr_count = '0;
        // a zero length never exceeds the limit and leaves nothing due
        if (len > max_len) begin
          step_results = {step_results, OVERSIZE_RES};
          dropping = 1'b1;
        end else begin
          remaining = len;
        end
      end
    end
    if (b.chunk_end) dropping = 1'b0;
    if (b.stream_end) begin
      if (hdr_count != 2'd0 || remaining != 32'd0) step_results = {step_results, ABORT_RES};
      hdr_shift = '0;
      hdr_count = '0;
      remaining = '0;
      dropping = 1'b0;
    end
    if (step_results.size() > 0) begin
      r = step_results.pop_back();
      r.run_last = 1'b1;
      step_results = {step_results, r};
    end
  endfunction

  function automatic row_t model_row(input beat_t b);
    return '{b, 1'b0, 2'd0, NO_RESULT, NO_RESULT};
  endfunction

  function automatic void check_field(input string what, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0h, got %0h", $time, what, want, got);
      mismatches++;
    end
  endfunction

  task automatic send_beat(input row_t row);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    {data_byte, has_byte, chunk_end, stream_end} <= row.beat;
    do @(posedge clk); while (in_stall);
    deframe_beat(row.beat);
    if (row.typed) begin
      if (row.count > 2'd0) due_results = {due_results, row.r0};
      if (row.count > 2'd1) due_results = {due_results, row.r1};
    end else begin
      due_results = {due_results, step_results};
    end
  endtask

  // One framed message with random content; sometimes oversize, cut short or closed.
  task automatic send_message();
    beat_t       body [$];
    beat_t       b;
    logic [31:0] len;
    int          pick;
    int          n_pay;
    int          keep;
    bit          close;
    close = 1'b0;
    pick = $urandom_range(99);
    if (pick < 55) len = $urandom_range(12);
    else if (pick < 65) len = max_len;
    else if (pick < 80) len = max_len + 32'd1;
    else if (pick < 90) len = $urandom_range(40);
    else len = $urandom();
    for (int i = 3; i >= 0; i--) begin
      b = '{len[8*i +: 8], 1'b1, 1'b0, 1'b0};
      body = {body, b};
    end
    if (len > max_len) begin
      if ($urandom_range(1) == 1) body[3].chunk_end = 1'b1;
    end else begin
      n_pay = (len > 32'd20) ? $urandom_range(20) : int'(len);
      close = (len > 32'd20);
      repeat (n_pay) begin
        b = '{8'($urandom()), 1'b1, 1'b0, 1'b0};
        body = {body, b};
      end
    end
    // cut the message short with a close
    if ($urandom_range(99) < 8) begin
      keep = $urandom_range(body.size() - 1) + 1;
      while (body.size() > keep) void'(body.pop_back());
      close = 1'b1;
    end
    if (close || $urandom_range(99) < 5) begin
      b = body.pop_back();
      b.stream_end = 1'b1;
      body = {body, b};
    end
    foreach (body[i]) begin
      if ($urandom_range(99) < 12) body[i].chunk_end = 1'b1;
      if ($urandom_range(99) < 6) begin
        b = '{8'($urandom()), 1'b0, 1'($urandom_range(9) == 0), 1'b0};
        send_beat(model_row(b));
        sent_beats++;
      end
      send_beat(model_row(body[i]));
      sent_beats++;
    end
  endtask

  // Hold input until every due result has arrived, then let the pipeline settle.
  task automatic drain();
    in_valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic reg_access(input logic write, input logic [2:0] addr,
                            input logic [31:0] wdata, output logic [31:0] rdata);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= write;
    paddr <= addr;
    pwdata <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    if (write && addr == MAX_LENGTH_ADDR) max_len = wdata;
  endtask

  task automatic check_max_length();
    logic [31:0] rd;
    reg_access(1'b0, MAX_LENGTH_ADDR, 32'd0, rd);
    if (rd !== max_len) begin
      $display("%0t: max_length read expected %0h, got %0h", $time, max_len, rd);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (due_results.size() == 0) begin
        $display("%0t: result with none due: expected nothing, got kind %0d byte %0h",
                 $time, result_kind, payload_byte);
        mismatches++;
      end else begin
        head_result = due_results.pop_front();
        check_field("result_kind", 8'(head_result.kind), 8'(result_kind));
        check_field("payload_byte", head_result.payload, payload_byte);
        check_field("message_last", 8'(head_result.message_last), 8'(message_last));
        check_field("run_last", 8'(head_result.run_last), 8'(run_last));
      end
    end
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("length_prefix_deframer_tb NOT OK");
      $finish;
    end
  end

  initial begin
    logic [31:0] new_max;
    logic [31:0] rd;
    beat_t       b;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    check_max_length();

    for (int i = 0; i < DIRECTED_COUNT; i++) send_beat(DIRECTED_ROWS[i]);
    drain();

    for (int phase = 0; phase < PHASES; phase++) begin
      send_idle_pct = (phase < 2) ? 25 : (phase < 4) ? 73 : 0;
      recv_idle_pct = (phase < 2) ? 73 : (phase < 4) ? 25 : 0;
      case (phase)
        0: new_max = 32'hFFFF_FFFF;
        1: new_max = 32'd1;
        2: new_max = 32'd0;
        3: new_max = $urandom_range(40, 2);
        4: new_max = MAX_LENGTH_RESET;
        default: new_max = $urandom();
      endcase
      reg_access(1'b1, MAX_LENGTH_ADDR, new_max, rd);
      check_max_length();
      if (phase == 3) begin
        // write to an unmapped index: the limit must not move
        reg_access(1'b1, UNUSED_ADDR, 32'h0000_0007, rd);
        check_max_length();
      end
      sent_beats = 0;
      while (sent_beats < BEATS_PER_PHASE) begin
        if ($urandom_range(99) < 10) begin
          b = '{8'($urandom()), 1'($urandom()), 1'($urandom_range(3) == 0),
                1'($urandom_range(7) == 0)};
          send_beat(model_row(b));
          sent_beats++;
        end else begin
          send_message();
        end
      end
      drain();
    end

    if (mismatches == 0) begin
      $display("length_prefix_deframer_tb OK");
    end else begin
      $display("length_prefix_deframer_tb NOT OK");
    end
    $finish;
  end

endmodule
